// ===== hw/rtl/bmpu_pkg.sv =====
// Shared types and constants for the BMP pixel unpacker.
// Used by bmpu_walker and bmp_pixel_unpacker; depends on nothing else.
package bmpu_pkg;

	localparam int MAX_WIDTH     = 4096;
	localparam int MAX_HEIGHT    = 4096;
	localparam int PALETTE_DEPTH = 256;

	localparam int DIM_W   = 13;                         // image_width / image_height
	localparam int COORD_W = 12;                         // pixel_row / pixel_col
	localparam int BIR_W   = 14;                         // byte position inside a stored row
	localparam int COL_W   = 14;                         // column counter
	localparam int ROWB_W  = 15;                         // row length in bytes, up to 16384
	localparam int PAL_AW  = $clog2(PALETTE_DEPTH);

	localparam logic [DIM_W-1:0] MAX_WIDTH_C  = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MAX_HEIGHT_C = DIM_W'(MAX_HEIGHT);

	// Pixel modes.
	localparam logic [1:0] MODE_PAL8  = 2'd0;
	localparam logic [1:0] MODE_RGB24 = 2'd1;
	localparam logic [1:0] MODE_RGB32 = 2'd2;

	// Input operations.
	localparam logic OP_PAL_WRITE = 1'b0;
	localparam logic OP_BODY      = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] REG_PIXEL_MODE   = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;
	localparam logic [1:0] REG_TOP_DOWN     = 2'd3;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	typedef struct packed {
		logic [1:0]       mode;
		logic [DIM_W-1:0] width;     // already clamped to 1..MAX_WIDTH
		logic [DIM_W-1:0] height;    // already clamped to 1..MAX_HEIGHT
		logic             top_down;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [7:0]         c0;
		logic [7:0]         c1;
		logic [7:0]         c2;
		logic               last;
		logic               use_pal;  // channels come from the palette read
	} pix_meta_t;

endpackage

// ===== hw/rtl/bmpu_walker.sv =====
// Row and pixel position tracking for the BMP pixel unpacker: byte gathering,
// padding skip and destination coordinates. Depends on bmpu_pkg.
module bmpu_walker (
	input  logic                clk,
	input  logic                arst_n,
	input  bmpu_pkg::cfg_t      cfg,
	input  logic                step,       // a body byte is accepted
	input  logic [7:0]          body_byte,
	output logic                emit,       // this byte completes a pixel
	output bmpu_pkg::pix_meta_t meta
);

	logic [23:0]                   gather_q;
	logic [1:0]                    bip_q;
	logic [bmpu_pkg::BIR_W-1:0]    bir_q;
	logic [bmpu_pkg::COL_W-1:0]    col_q;
	logic [bmpu_pkg::COORD_W-1:0]  rc_q;

	logic                          mode_ok;
	logic [2:0]                    bpp;
	logic [bmpu_pkg::ROWB_W-1:0]   w_ext;
	logic [bmpu_pkg::ROWB_W-1:0]   data_bytes;
	logic [bmpu_pkg::ROWB_W-1:0]   row_bytes;
	logic [bmpu_pkg::ROWB_W-1:0]   bir_inc;
	logic                          in_data;
	logic                          complete;
	logic                          row_end;
	logic [bmpu_pkg::DIM_W-1:0]    rc_ext;
	logic [bmpu_pkg::DIM_W-1:0]    rc_inc;
	logic [bmpu_pkg::DIM_W-1:0]    row_full;
	logic [bmpu_pkg::ROWB_W-1:0]   col_inc;
	logic [23:0]                   gather_nxt;

	always_comb begin
		w_ext      = bmpu_pkg::ROWB_W'(cfg.width);
		mode_ok    = 1'b1;
		bpp        = 3'd0;
		data_bytes = '0;
		unique case (cfg.mode)
			bmpu_pkg::MODE_PAL8: begin
				bpp        = 3'd1;
				data_bytes = w_ext;
			end
			bmpu_pkg::MODE_RGB24: begin
				bpp        = 3'd3;
				data_bytes = w_ext + (w_ext << 1);
			end
			bmpu_pkg::MODE_RGB32: begin
				bpp        = 3'd4;
				data_bytes = w_ext << 2;
			end
			default: begin
				mode_ok = 1'b0;
			end
		endcase
		row_bytes = (data_bytes + bmpu_pkg::ROWB_W'(3)) & ~bmpu_pkg::ROWB_W'(3);
		bir_inc   = bmpu_pkg::ROWB_W'(bir_q) + bmpu_pkg::ROWB_W'(1);
		in_data   = bmpu_pkg::ROWB_W'(bir_q) < data_bytes;
		complete  = ({1'b0, bip_q} + 3'd1) >= bpp;
		row_end   = bir_inc >= row_bytes;
		emit      = step && mode_ok && in_data && complete;

		rc_ext = bmpu_pkg::DIM_W'(rc_q);
		rc_inc = rc_ext + bmpu_pkg::DIM_W'(1);
		if (cfg.top_down) begin
			row_full = rc_ext;
		end else if (rc_ext < cfg.height) begin
			row_full = cfg.height - bmpu_pkg::DIM_W'(1) - rc_ext;
		end else begin
			row_full = '0;
		end
		col_inc = bmpu_pkg::ROWB_W'(col_q) + bmpu_pkg::ROWB_W'(1);

		case (bip_q)
			2'd0:    gather_nxt = gather_q | {16'h0000, body_byte};
			2'd1:    gather_nxt = gather_q | {8'h00, body_byte, 8'h00};
			2'd2:    gather_nxt = gather_q | {body_byte, 16'h0000};
			default: gather_nxt = gather_q;
		endcase

		meta.row     = row_full[bmpu_pkg::COORD_W-1:0];
		meta.col     = col_q[bmpu_pkg::COORD_W-1:0];
		meta.last    = (col_inc >= bmpu_pkg::ROWB_W'(cfg.width)) && (rc_inc >= cfg.height);
		meta.use_pal = (cfg.mode == bmpu_pkg::MODE_PAL8);
		if (cfg.mode == bmpu_pkg::MODE_RGB24) begin
			// Stored order is blue, green, red; the last byte arrives live.
			meta.c0 = body_byte;
			meta.c1 = gather_q[15:8];
			meta.c2 = gather_q[7:0];
		end else begin
			meta.c0 = gather_q[7:0];
			meta.c1 = gather_q[15:8];
			meta.c2 = gather_q[23:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gather_q <= '0;
			bip_q    <= '0;
			bir_q    <= '0;
			col_q    <= '0;
			rc_q     <= '0;
		end else if (step && mode_ok) begin
			if (row_end) begin
				bir_q    <= '0;
				bip_q    <= '0;
				gather_q <= '0;
				col_q    <= '0;
				if (rc_inc >= cfg.height) begin
					rc_q <= '0;
				end else begin
					rc_q <= rc_inc[bmpu_pkg::COORD_W-1:0];
				end
			end else begin
				bir_q <= bir_inc[bmpu_pkg::BIR_W-1:0];
				if (in_data) begin
					if (complete) begin
						col_q    <= col_inc[bmpu_pkg::COL_W-1:0];
						bip_q    <= '0;
						gather_q <= '0;
					end else begin
						gather_q <= gather_nxt;
						bip_q    <= bip_q + 2'd1;
					end
				end
			end
		end
	end

endmodule

// ===== hw/rtl/bmp_pixel_unpacker.sv =====
// Top level of the BMP pixel unpacker: configuration registers, palette
// memory and the two-stage output pipeline. Depends on bmpu_pkg and bmpu_walker.
//
// Usage:
// The input channel (in_valid / in_stall) carries one beat per cycle while in_stall is low: either a
// palette write (operation 0: palette_index, palette_word) or one byte of the
// BMP pixel body (operation 1: body_byte), padding bytes included. Software
// sets pixel_mode, image_width, image_height and top_down through the cfg
// channel (cfg_valid / cfg_ready, always ready) while no beat is in flight.
// The output channel (out_valid / out_stall) gives one RGBA pixel with its
// destination row and column for each beat that completes a pixel.
// Throughput is one input beat per cycle in every mode while in_stall is low.
// A completed pixel passes the synchronous palette read, then the output register.
// When out_stall holds, the output register and the stage before it fill and
// in_stall rises; nothing is lost and beats resume at full rate.
// Reset clears the position counters and the pipeline and loads the register
// defaults (32 bpp, 1 x 1, bottom-up). Palette contents are undefined after
// reset; every entry must be written before a pixel refers to it.
module bmp_pixel_unpacker (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	// Input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [7:0]  palette_index,
	input  logic [23:0] palette_word,
	input  logic [7:0]  body_byte,
	// Output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] pixel_row,
	output logic [11:0] pixel_col,
	output logic [7:0]  chan0,
	output logic [7:0]  chan1,
	output logic [7:0]  chan2,
	output logic [7:0]  alpha_out,
	output logic        last_pixel
);

	bmpu_pkg::cfg_t      cfg_q;
	logic [bmpu_pkg::DIM_W-1:0] dim_clamped;

	logic                accept;
	logic                step;
	logic                emit;
	bmpu_pkg::pix_meta_t meta;

	logic [23:0]         pal_mem [bmpu_pkg::PALETTE_DEPTH];
	logic [23:0]         pal_rdata_q;
	logic                pal_we;
	logic                pal_re;

	logic                s1_valid_q;
	bmpu_pkg::pix_meta_t meta_s1;
	logic                s1_adv;
	logic                out_valid_q;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (cfg_data == '0) begin
			dim_clamped = bmpu_pkg::DIM_W'(1);
		end else if (cfg_data > bmpu_pkg::MAX_WIDTH_C) begin
			dim_clamped = bmpu_pkg::MAX_WIDTH_C;
		end else begin
			dim_clamped = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= bmpu_pkg::MODE_RGB32;
			cfg_q.width    <= bmpu_pkg::DIM_W'(1);
			cfg_q.height   <= bmpu_pkg::DIM_W'(1);
			cfg_q.top_down <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bmpu_pkg::REG_PIXEL_MODE:   cfg_q.mode     <= cfg_data[1:0];
				bmpu_pkg::REG_IMAGE_WIDTH:  cfg_q.width    <= dim_clamped;
				bmpu_pkg::REG_IMAGE_HEIGHT: begin
					cfg_q.height <= (dim_clamped > bmpu_pkg::MAX_HEIGHT_C) ?
						bmpu_pkg::MAX_HEIGHT_C : dim_clamped;
				end
				bmpu_pkg::REG_TOP_DOWN:     cfg_q.top_down <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The stage before the output register moves whenever the output
	// register is empty or being taken.
	assign s1_adv   = !out_valid_q || !out_stall;
	assign in_stall = s1_valid_q && !s1_adv;
	assign accept   = in_valid && !in_stall;
	assign step     = accept && (operation == bmpu_pkg::OP_BODY);
	assign pal_we   = accept && (operation == bmpu_pkg::OP_PAL_WRITE);
	assign pal_re   = step && (cfg_q.mode == bmpu_pkg::MODE_PAL8);

	bmpu_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.step      (step),
		.body_byte (body_byte),
		.emit      (emit),
		.meta      (meta)
	);

	// A write and a read never share an edge, so a read always sees every
	// earlier write.
	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[palette_index] <= palette_word;
		end
		if (pal_re) begin
			pal_rdata_q <= pal_mem[body_byte];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			meta_s1 <= meta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && emit) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_q) begin
			pixel_row  <= meta_s1.row;
			pixel_col  <= meta_s1.col;
			last_pixel <= meta_s1.last;
			if (meta_s1.use_pal) begin
				chan0 <= pal_rdata_q[23:16];
				chan1 <= pal_rdata_q[15:8];
				chan2 <= pal_rdata_q[7:0];
			end else begin
				chan0 <= meta_s1.c0;
				chan1 <= meta_s1.c1;
				chan2 <= meta_s1.c2;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign alpha_out = bmpu_pkg::ALPHA_OPAQUE;

	a_emit_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit) |=> s1_valid_q)
		else $error("completed pixel did not enter the first stage");

	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_valid_q))
		else $error("output became valid without a pending pixel");

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!s1_valid_q && !out_valid_q) |-> !in_stall)
		else $error("input stalled with an empty pipeline");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && out_valid_q && out_stall))
		else $error("input stalled while the pipeline could move");

endmodule

// ===== bench/bmp_pixel_unpacker_test.sv =====
// Self-checking bench for bmp_pixel_unpacker: a directed start, then random images
// in all pixel modes under several idle and stall patterns. Depends on bmpu_pkg
// and the bmp_pixel_unpacker RTL only.
module bmp_pixel_unpacker_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 10;
	localparam int RANDOM_BEATS   = 1800;
	localparam int DRAIN_CYCLES   = 6;
	localparam int FINAL_CYCLES   = 10;
	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int MAX_REPORTS    = 50;

	// Mode 3 is not a valid pixel mode; the block ignores body bytes in it.
	localparam logic [1:0] MODE_NONE = 2'd3;

	typedef struct packed {
		logic        op;
		logic [7:0]  pal_idx;
		logic [23:0] pal_word;
		logic [7:0]  body;
		bit          drain_first;   // hold this beat back until all pixels are out
	} beat_t;

	typedef struct packed {
		logic [11:0] row;
		logic [11:0] col;
		logic [7:0]  c0;
		logic [7:0]  c1;
		logic [7:0]  c2;
		logic [7:0]  alpha;
		logic        last;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = bmpu_pkg::REG_PIXEL_MODE;
	logic [12:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = bmpu_pkg::OP_PAL_WRITE;
	logic [7:0]  palette_index = '0;
	logic [23:0] palette_word = '0;
	logic [7:0]  body_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [11:0] pixel_row;
	logic [11:0] pixel_col;
	logic [7:0]  chan0;
	logic [7:0]  chan1;
	logic [7:0]  chan2;
	logic [7:0]  alpha_out;
	logic        last_pixel;

	bmp_pixel_unpacker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.palette_index(palette_index),
		.palette_word (palette_word),
		.body_byte    (body_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_row    (pixel_row),
		.pixel_col    (pixel_col),
		.chan0        (chan0),
		.chan1        (chan1),
		.chan2        (chan2),
		.alpha_out    (alpha_out),
		.last_pixel   (last_pixel)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	beat_t  pending_beats[$];
	pixel_t expected_pixels[$];
	int     mismatch_count = 0;
	int     cfg_beats = 0;
	int     quiet_cycles = 0;
	int     send_idle_pct = 0;
	int     stall_pct = 0;
	bit     in_taken = 1'b0;
	bit     hold_req = 1'b0;
	bit     hold_ack = 1'b0;
	int     hold_left = 0;
	bit     pause_next = 1'b0;

	// Stimulus side bookkeeping: which palette entries may be referenced.
	bit     pal_written[256];
	int     color_indices[$];

	// Shadow of the block: registers, stream position and palette.
	logic [1:0]  reg_mode = bmpu_pkg::MODE_RGB32;
	logic [12:0] reg_width = 13'd1;
	logic [12:0] reg_height = 13'd1;
	logic        reg_top_down = 1'b0;
	logic [23:0] gather_bytes = '0;
	int unsigned pixel_byte_pos = 0;
	int unsigned row_byte_pos = 0;
	int unsigned col_count = 0;
	int unsigned row_count = 0;
	logic [23:0] palette_copy[256];

	task automatic report_error(input string msg);
		if (mismatch_count < MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("%s got %0h, want %0h", name, got, want));
	endtask

	task automatic apply_register(input logic [1:0] idx, input logic [12:0] value);
		case (idx)
			bmpu_pkg::REG_PIXEL_MODE:   reg_mode = value[1:0];
			bmpu_pkg::REG_IMAGE_WIDTH:  reg_width = value;
			bmpu_pkg::REG_IMAGE_HEIGHT: reg_height = value;
			bmpu_pkg::REG_TOP_DOWN:     reg_top_down = value[0];
			default:                    ;
		endcase
	endtask

	// Advances the shadow state by one accepted beat and queues the pixel it completes.
	task automatic predict_pixel(input logic op, input logic [7:0] idx, input logic [23:0] word,
			input logic [7:0] b);
		int unsigned bpp;
		int unsigned wid;
		int unsigned hgt;
		int unsigned data_len;
		int unsigned row_len;
		int unsigned dest_row;
		logic [23:0] color;
		pixel_t      px;
		if (op == bmpu_pkg::OP_PAL_WRITE) begin
			palette_copy[idx] = word;
			return;
		end
		case (reg_mode)
			bmpu_pkg::MODE_PAL8:  bpp = 1;
			bmpu_pkg::MODE_RGB24: bpp = 3;
			bmpu_pkg::MODE_RGB32: bpp = 4;
			default:              return;
		endcase
		wid = (reg_width == 0) ? 1 :
			((reg_width > bmpu_pkg::MAX_WIDTH) ? bmpu_pkg::MAX_WIDTH : reg_width);
		hgt = (reg_height == 0) ? 1 :
			((reg_height > bmpu_pkg::MAX_HEIGHT) ? bmpu_pkg::MAX_HEIGHT : reg_height);
		data_len = wid * bpp;
		row_len = (data_len + 3) & ~32'd3;

		if (row_byte_pos < data_len) begin
			if (pixel_byte_pos + 1 >= bpp) begin
				if (bpp == 1) begin
					color = palette_copy[b];
					px.c0 = color[23:16];
					px.c1 = color[15:8];
					px.c2 = color[7:0];
				end else if (bpp == 3) begin
					px.c0 = b;
					px.c1 = gather_bytes[15:8];
					px.c2 = gather_bytes[7:0];
				end else begin
					px.c0 = gather_bytes[7:0];
					px.c1 = gather_bytes[15:8];
					px.c2 = gather_bytes[23:16];
				end
				// Bottom-up images count rows up from the bottom; a row past the end reads as 0.
				if (reg_top_down)
					dest_row = row_count;
				else
					dest_row = (row_count < hgt) ? (hgt - 1 - row_count) : 0;
				px.row = dest_row[11:0];
				px.col = col_count[11:0];
				px.alpha = bmpu_pkg::ALPHA_OPAQUE;
				px.last = (col_count + 1 >= wid) && (row_count + 1 >= hgt);
				expected_pixels.push_back(px);
				col_count = (col_count + 1) & 32'hFFFF;
				pixel_byte_pos = 0;
				gather_bytes = '0;
			end else begin
				gather_bytes = gather_bytes | (24'(b) << (8 * pixel_byte_pos));
				pixel_byte_pos = (pixel_byte_pos + 1) & 3;
			end
		end

		row_byte_pos++;
		if (row_byte_pos >= row_len) begin
			row_byte_pos = 0;
			pixel_byte_pos = 0;
			gather_bytes = '0;
			col_count = 0;
			row_count++;
			if (row_count >= hgt)
				row_count = 0;
		end
	endtask

	// Input side: one beat offered at a time, held while stalled.
	always @(negedge clk) begin : driver
		beat_t next_beat;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct
					&& (!pending_beats[0].drain_first || expected_pixels.size() == 0)) begin
				next_beat = pending_beats.pop_front();
				in_valid      <= 1'b1;
				operation     <= next_beat.op;
				palette_index <= next_beat.pal_idx;
				palette_word  <= next_beat.pal_word;
				body_byte     <= next_beat.body;
			end else begin
				in_valid      <= 1'b0;
				operation     <= 1'($urandom);
				palette_index <= 8'($urandom);
				palette_word  <= 24'($urandom);
				body_byte     <= 8'($urandom);
			end
		end
	end

	// Output side back-pressure, with an occasional long hold-off.
	always @(negedge clk) begin : receiver
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : monitor
		pixel_t want;
		bit     cfg_taken;
		bit     out_taken;
		if (arst_n) begin
			cfg_taken = cfg_valid && cfg_ready;
			in_taken = in_valid && !in_stall;
			out_taken = out_valid && !out_stall;
			if (cfg_taken) begin
				apply_register(cfg_index, cfg_data);
				cfg_beats++;
			end
			if (in_taken)
				predict_pixel(operation, palette_index, palette_word, body_byte);
			if (out_taken) begin
				if (expected_pixels.size() == 0) begin
					report_error($sformatf("pixel row %0d col %0d with none expected",
						pixel_row, pixel_col));
				end else begin
					want = expected_pixels.pop_front();
					check_field("pixel_row", 32'(pixel_row), 32'(want.row));
					check_field("pixel_col", 32'(pixel_col), 32'(want.col));
					check_field("chan0", 32'(chan0), 32'(want.c0));
					check_field("chan1", 32'(chan1), 32'(want.c1));
					check_field("chan2", 32'(chan2), 32'(want.c2));
					check_field("alpha_out", 32'(alpha_out), 32'(want.alpha));
					check_field("last_pixel", 32'(last_pixel), 32'(want.last));
				end
			end
			if (cfg_taken || in_taken || out_taken)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] no beat moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic queue_beat(input logic op, input logic [7:0] idx, input logic [23:0] word,
			input logic [7:0] b);
		beat_t bt;
		bt.op = op;
		bt.pal_idx = idx;
		bt.pal_word = word;
		bt.body = b;
		bt.drain_first = pause_next;
		pause_next = 1'b0;
		pending_beats.push_back(bt);
	endtask

	task automatic queue_palette(input logic [7:0] idx, input logic [23:0] word);
		queue_beat(bmpu_pkg::OP_PAL_WRITE, idx, word, 8'($urandom));
		if (!pal_written[idx]) begin
			pal_written[idx] = 1'b1;
			color_indices.push_back(idx);
		end
	endtask

	task automatic queue_body(input logic [7:0] b);
		queue_beat(bmpu_pkg::OP_BODY, 8'($urandom), 24'($urandom), b);
	endtask

	function automatic logic [7:0] pick_color_index();
		return 8'(color_indices[$urandom_range(color_indices.size() - 1)]);
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [12:0] value);
		int seen;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		seen = cfg_beats;
		do @(negedge clk); while (cfg_beats == seen);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [1:0] mode, input int w, input int h, input bit td);
		write_reg(bmpu_pkg::REG_PIXEL_MODE, 13'(mode));
		write_reg(bmpu_pkg::REG_IMAGE_WIDTH, 13'(w));
		write_reg(bmpu_pkg::REG_IMAGE_HEIGHT, 13'(h));
		write_reg(bmpu_pkg::REG_TOP_DOWN, 13'(td));
	endtask

	// Waits until no beat is queued or in flight and every pixel is out, then lets the
	// pipeline settle since padding bytes leave no pixel to wait for.
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_beats.size() != 0 || in_valid || expected_pixels.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		int          phase;
		int          random_beats;
		logic [1:0]  mode;
		int          w;
		int          h;
		int          wc;
		int          hc;
		int          bpp;
		int          row_len;
		int          img_len;
		int          n_body;
		int          k;
		int          extremes[5];
		extremes = '{0, 1, 4096, 4097, 8191};

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Register defaults after reset: one 32 bpp pixel, bottom-up.
		queue_body(8'h00);
		queue_body(8'hFF);
		queue_body(8'hA5);
		queue_body(8'h5A);
		wait_drained();

		// Palette mode, 3 x 2: extreme palette entries, padding, and a palette write
		// in the middle of a row that does not move the body position.
		set_config(bmpu_pkg::MODE_PAL8, 3, 2, 1'b0);
		queue_palette(8'h00, 24'h000000);
		queue_palette(8'hFF, 24'hFFFFFF);
		queue_palette(8'h5A, 24'h123456);
		queue_body(8'hFF);
		queue_body(8'h00);
		queue_body(8'h5A);
		queue_body(8'h00);
		queue_body(8'h5A);
		queue_palette(8'h81, 24'hABCDEF);
		queue_body(8'h81);
		queue_body(8'hFF);
		queue_body(8'h5A);
		wait_drained();

		set_config(bmpu_pkg::MODE_RGB24, 1, 1, 1'b1);
		queue_body(8'h11);
		queue_body(8'h22);
		queue_body(8'h33);
		queue_body(8'h44);
		wait_drained();

		set_config(MODE_NONE, 2, 2, 1'b0);
		queue_body(8'h77);
		queue_body(8'h88);
		wait_drained();

		random_beats = 0;
		for (phase = 0; random_beats < RANDOM_BEATS; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 63; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 63; end
				default: begin send_idle_pct = 19; stall_pct = 19; end
			endcase

			// The first phases pin the size extremes; large images are left unfinished
			// so the next setting starts with counters beyond its own limits.
			case (phase)
				0: begin mode = bmpu_pkg::MODE_RGB32; w = 8191; h = 8191; end
				1: begin mode = bmpu_pkg::MODE_PAL8;  w = 0;    h = 0;    end
				2: begin mode = MODE_NONE;            w = 5;    h = 2;    end
				3: begin mode = bmpu_pkg::MODE_RGB24; w = 4096; h = 4096; end
				default: begin
					mode = ($urandom_range(19) == 0) ? MODE_NONE : 2'($urandom_range(2));
					w = ($urandom_range(9) == 0) ? extremes[$urandom_range(4)] : $urandom_range(1, 12);
					h = ($urandom_range(9) == 0) ? extremes[$urandom_range(4)] : $urandom_range(1, 5);
				end
			endcase
			if (phase % 8 == 4 && mode == MODE_NONE)
				mode = bmpu_pkg::MODE_RGB24;
			set_config(mode, w, h, 1'($urandom));

			wc = (w == 0) ? 1 : ((w > bmpu_pkg::MAX_WIDTH) ? bmpu_pkg::MAX_WIDTH : w);
			hc = (h == 0) ? 1 : ((h > bmpu_pkg::MAX_HEIGHT) ? bmpu_pkg::MAX_HEIGHT : h);
			bpp = (mode == bmpu_pkg::MODE_PAL8) ? 1 :
				((mode == bmpu_pkg::MODE_RGB24) ? 3 : 4);
			row_len = (wc * bpp + 3) / 4 * 4;
			img_len = row_len * hc;
			if (mode == MODE_NONE)
				n_body = 8;
			else if (img_len > 400)
				n_body = $urandom_range(20, 120);
			else
				n_body = img_len * $urandom_range(1, (img_len > 150) ? 1 : 3);
			if (mode != MODE_NONE && $urandom_range(6) == 0)
				n_body = $urandom_range(1, n_body);
			if (phase % 8 == 4 && n_body < 60)
				n_body = 60;

			if (mode == bmpu_pkg::MODE_PAL8) begin
				repeat ($urandom_range(2, 8)) begin
					queue_palette(8'($urandom), 24'($urandom));
					random_beats++;
				end
			end
			for (k = 0; k < n_body; k++) begin
				if (phase % 5 == 1 && k == n_body / 2)
					pause_next = 1'b1;
				if ($urandom_range(24) == 0) begin
					queue_palette(8'($urandom), 24'($urandom));
					random_beats++;
				end
				// In palette mode every body byte, padding too, names a written entry.
				if (mode == bmpu_pkg::MODE_PAL8)
					queue_body(pick_color_index());
				else
					queue_body(8'($urandom));
				if (mode != MODE_NONE)
					random_beats++;
			end

			if (phase % 8 == 4)
				hold_req = ~hold_req;
			wait_drained();
		end

		wait_drained();
		repeat (FINAL_CYCLES) @(negedge clk);
		if (expected_pixels.size() != 0)
			report_error($sformatf("%0d pixels never came out", expected_pixels.size()));
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== bmp_pixel_unpacker.f =====
hw/rtl/bmpu_pkg.sv
hw/rtl/bmpu_walker.sv
hw/rtl/bmp_pixel_unpacker.sv
bench/bmp_pixel_unpacker_test.sv
